### rtl/bounded_deque_with_search_top_assert.svh
// assertion macros for the bounded deque with search
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define BDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bdq assertion failed");
`define BDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bdq assertion failed");
`else
`define BDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/bdq_pkg.sv
// shared types and constants of the bounded deque with search
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 16;
	localparam int FOUND_W   = 5;
	localparam int ENT_W     = 6;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_PREPEND = 3'd1,
		OP_POP     = 3'd2,
		OP_READ    = 3'd3,
		OP_SEARCH  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// per-transfer commands broadcast to every cell, already qualified
	typedef struct packed {
		logic cap;
		logic shift;
		logic append;
		logic search;
		logic read;
	} cell_ctrl_t;

endpackage

### rtl/bdq_cell.sv
// one storage cell of the deque: holds an entry, shifts right, compares
`timescale 1ns / 1ps

module bdq_cell import bdq_pkg::*; #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 6
) (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic [CNT_W-1:0]   count,
	input  logic [VAL_W-1:0]   value,
	input  logic [POS_W-1:0]   position,
	input  logic [VAL_W-1:0]   left_data,
	output logic [VAL_W-1:0]   data_q,
	output logic               match_s1,
	output logic [VAL_W-1:0]   rdata_s1
);

	localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(CELL_IDX);
	localparam logic [POS_W-1:0] IDX_POS = POS_W'(CELL_IDX);

	logic occ;
	logic sel;
	logic hit;

	assign occ = IDX_CNT < count;
	assign sel = ctrl.read && occ && (position == IDX_POS);
	assign hit = ctrl.search && occ && (data_q == value);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= left_data;
		end else if (ctrl.append && (count == IDX_CNT)) begin
			data_q <= value;
		end
	end

	// compare results use the entries as they were before the transfer
	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			match_s1 <= hit;
			rdata_s1 <= sel ? data_q : '0;
		end
	end

endmodule

### rtl/bounded_deque_with_search_top.sv
// bounded deque with search: one result for each input transfer
// a new item is taken only once the last one's result is registered: cells
// compare, then the result stage reduces their outputs into the result register
// a result may wait in its register while the next item is taken
// reset clears the entry count and handshake state; cell contents are unknown
`timescale 1ns / 1ps

`include "bounded_deque_with_search_top_assert.svh"

module bounded_deque_with_search_top import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [2:0]                operation,
	input  logic signed [VAL_W-1:0]   value,
	input  logic [POS_W-1:0]          position,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [2:0]                status,
	output logic signed [VAL_W-1:0]   data,
	output logic [FOUND_W-1:0]        found_at,
	output logic [ENT_W-1:0]          entries
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic               accept;
	logic               busy_q;
	logic [CNT_W-1:0]   count_q;
	logic               full;
	logic               empty;
	cell_ctrl_t         ctrl;
	logic [2:0]         op_s1;
	logic [2:0]         status_s1;
	logic [2:0]         pre_status;

	logic [VAL_W-1:0]   cell_data  [DEPTH];
	logic [VAL_W-1:0]   shift_in   [DEPTH];
	logic [VAL_W-1:0]   cell_rdata [DEPTH];
	logic [DEPTH-1:0]   cell_match;

	logic               out_free;
	logic               rsp_valid_q;
	logic [2:0]         status_q;
	logic [VAL_W-1:0]   data_q;
	logic [FOUND_W-1:0] found_q;
	logic [ENT_W-1:0]   ent_q;
	logic [VAL_W-1:0]   rd_or;
	logic               hit_any;
	logic [IDX_W-1:0]   hit_idx;

	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign full      = count_q == FULL_CNT;
	assign empty     = count_q == '0;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ctrl        = '0;
		ctrl.cap    = accept;
		ctrl.shift  = accept && (operation == OP_PREPEND) && !full;
		ctrl.append = accept && (operation == OP_APPEND) && !full;
		ctrl.search = accept && (operation == OP_SEARCH);
		ctrl.read   = accept && (operation == OP_READ);
	end

	always_comb begin
		pre_status = ST_OK;
		unique case (operation)
			OP_APPEND, OP_PREPEND: begin
				if (full) pre_status = ST_FULL;
			end
			OP_POP: begin
				if (empty) pre_status = ST_EMPTY;
			end
			OP_READ: begin
				if ({{(POS_W + 1 - CNT_W){1'b0}}, count_q} <= {1'b0, position})
					pre_status = ST_RANGE;
			end
			OP_SEARCH: begin
				pre_status = ST_NOTFOUND;
			end
			default: begin
				pre_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				if (((operation == OP_APPEND) || (operation == OP_PREPEND)) && !full)
					count_q <= count_q + 1'b1;
				else if ((operation == OP_POP) && !empty)
					count_q <= count_q - 1'b1;
			end else if (busy_q && out_free) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			status_s1 <= pre_status;
		end
	end

	// cell 0 takes the new value on prepend, the rest shift from the left
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign shift_in[g] = value;
		end else begin : g_body
			assign shift_in[g] = cell_data[g-1];
		end

		bdq_cell #(
			.CELL_IDX (g),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.value     (value),
			.position  (position),
			.left_data (shift_in[g]),
			.data_q    (cell_data[g]),
			.match_s1  (cell_match[g]),
			.rdata_s1  (cell_rdata[g])
		);
	end

	// at most one cell holds nonzero read data
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_rdata[i];
		end
	end

	// first matching cell from the front wins
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (busy_q && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// the count is captured here so a waiting result keeps it while the next item runs
	always_ff @(posedge clk) begin
		if (busy_q && out_free) begin
			data_q <= rd_or;
			ent_q  <= ENT_W'(count_q);
			if (op_s1 == OP_SEARCH) begin
				status_q <= hit_any ? ST_OK : ST_NOTFOUND;
				found_q  <= hit_any ? FOUND_W'(hit_idx) : '0;
			end else begin
				status_q <= status_s1;
				found_q  <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign found_at  = found_q;
	assign entries   = ent_q;

	`BDQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT)
	`BDQ_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy_q && !accept)
	`BDQ_ASSERT_NXT(a_full_push_hold, clk, arst_n, accept && full && ((operation == OP_APPEND) || (operation == OP_PREPEND)), $stable(count_q))
	`BDQ_ASSERT_IMP(a_full_status, clk, arst_n, rsp_valid && (status == ST_FULL), entries == ENT_W'(FULL_CNT))

endmodule
